[hdl/ecpq_pkg.sv]
// Package for the event calendar: sizes, queue entry and cell control types.
package ecpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W = 32;
  localparam int DELAY_W = 16;
  localparam int EVENT_W = 8;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_POP      = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [TIME_W-1:0]  tstamp;
    logic [EVENT_W-1:0] code;
  } entry_t;

  // Broadcast to every cell in the chain for the current item.
  typedef struct packed {
    logic   pop;
    logic   ins;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

[hdl/ecpq_ifs.sv]
// Handshake interfaces for the command and result channels.
interface ecpq_cmd_if;
  import ecpq_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [DELAY_W-1:0] delay;
  logic [EVENT_W-1:0] event_code;
  modport source (output valid, output opcode, output delay, output event_code, input ready);
  modport sink (input valid, input opcode, input delay, input event_code, output ready);
endinterface

interface ecpq_res_if;
  import ecpq_pkg::*;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  event_time;
  logic [EVENT_W-1:0] event_id;
  logic               queue_empty;
  logic               queue_overflow;
  modport source (output valid, output event_time, output event_id, output queue_empty,
                  output queue_overflow, input ready);
  modport sink (input valid, input event_time, input event_id, input queue_empty,
                input queue_overflow, output ready);
endinterface

[hdl/ecpq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts it toward either neighbor.
module ecpq_cell
  import ecpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  entry_t     left_data,
  input  logic       left_take,
  input  entry_t     right_data,
  output entry_t     data,
  output logic       take
);

  entry_t data_next;

  // A cell yields its slot when it is empty or holds a strictly later time,
  // so equal times keep their scheduling order.
  assign take = !occ || (data.tstamp > ctrl.new_entry.tstamp);

  always_comb begin
    data_next = data;
    if (ctrl.pop) begin
      data_next = right_data;
    end else if (ctrl.ins) begin
      if (take && !left_take) begin
        data_next = ctrl.new_entry;
      end else if (take) begin
        data_next = left_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[hdl/event_calendar_priority_queue_top.sv]
// Event calendar built as a chain of QUEUE_DEPTH sorting cells with the earliest entry in cell 0.
// For each command item, a schedule compares the new time against every cell at once and the
// later entries move one cell down the chain, while a pop moves every entry one cell toward the
// head. The result sits in an output register, so a new item is accepted every cycle as long as
// the result channel takes its items.
module event_calendar_priority_queue_top
  import ecpq_pkg::*;
(
  input logic         clk,
  input logic         rst,
  ecpq_cmd_if.sink    cmd,
  ecpq_res_if.source  result
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [TIME_W-1:0]  current_time;
  logic [TIME_W-1:0]  current_time_next;
  logic               out_valid;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic [TIME_W:0]    sum;
  cell_ctrl_t         ctrl;
  entry_t             cell_data [QUEUE_DEPTH];
  logic               cell_take [QUEUE_DEPTH];
  logic               occ [QUEUE_DEPTH];

  assign cmd.ready = !out_valid || result.ready;
  assign accept = cmd.valid && cmd.ready;
  assign is_full = (count == COUNT_W'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  // Saturating add of the delay to the current time.
  assign sum = {1'b0, current_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, cmd.delay};

  always_comb begin
    ctrl.pop = accept && (cmd.opcode == OP_POP) && !is_empty;
    ctrl.ins = accept && (cmd.opcode == OP_SCHEDULE) && !is_full;
    ctrl.new_entry.tstamp = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    ctrl.new_entry.code = cmd.event_code;
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      assign occ[gi] = (COUNT_W'(gi) < count);
      if (gi == 0) begin : g_head
        ecpq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occ        (occ[gi]),
          .left_data  (ctrl.new_entry),
          .left_take  (1'b0),
          .right_data (cell_data[gi + 1]),
          .data       (cell_data[gi]),
          .take       (cell_take[gi])
        );
      end else if (gi == QUEUE_DEPTH - 1) begin : g_tail
        ecpq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occ        (occ[gi]),
          .left_data  (cell_data[gi - 1]),
          .left_take  (cell_take[gi - 1]),
          .right_data (cell_data[gi]),
          .data       (cell_data[gi]),
          .take       (cell_take[gi])
        );
      end else begin : g_mid
        ecpq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occ        (occ[gi]),
          .left_data  (cell_data[gi - 1]),
          .left_take  (cell_take[gi - 1]),
          .right_data (cell_data[gi + 1]),
          .data       (cell_data[gi]),
          .take       (cell_take[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    current_time_next = current_time;
    if (ctrl.pop) begin
      count_next = count - COUNT_W'(1);
      current_time_next = cell_data[0].tstamp;
    end else if (ctrl.ins) begin
      count_next = count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      current_time <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      current_time <= current_time_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.event_time <= ctrl.pop ? cell_data[0].tstamp : '0;
      result.event_id <= ctrl.pop ? cell_data[0].code : '0;
      result.queue_empty <= (cmd.opcode == OP_POP) && is_empty;
      result.queue_overflow <= (cmd.opcode == OP_SCHEDULE) && is_full;
    end
  end

  assign result.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.opcode == OP_SCHEDULE) && is_full |=>
      (count == $past(count)) && result.queue_overflow)
    else $error("schedule into a full queue changed the count or missed overflow");

  a_pop_time: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> (current_time == $past(cell_data[0].tstamp)) &&
      (count == $past(count) - COUNT_W'(1)))
    else $error("pop did not advance time or count correctly");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    occ[1] |-> cell_data[0].tstamp <= cell_data[1].tstamp)
    else $error("head entries out of time order");
`endif

endmodule
